[sv/request_circuit_breaker_top_macros.svh]
// assertion helpers for the circuit breaker
`ifndef REQUEST_CIRCUIT_BREAKER_TOP_MACROS_SVH
`define REQUEST_CIRCUIT_BREAKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rcb_pkg.sv]
`timescale 1ns / 1ps

package rcb_pkg;

    // width of the statistics counters
    localparam int COUNT_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int CMP_W       = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

    localparam int RUN_W  = 16;
    localparam int AGE_W  = 32;
    localparam int CIDX_W = 8;

    // breaker states
    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_HALF   = 2'd2;

    // event kinds
    localparam logic [2:0] REQ_QUERY   = 3'd0;
    localparam logic [2:0] REQ_OUTCOME = 3'd1;
    localparam logic [2:0] REQ_TICK    = 3'd2;
    localparam logic [2:0] REQ_FORCE   = 3'd3;
    localparam logic [2:0] REQ_RESET   = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FAILURE_LIMIT   = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_MIN_TOTAL_CALLS = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_PROBE_LIMIT     = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] CFG_RECOVERY_TICKS  = CIDX_W'(3);

    typedef struct packed {
        logic [2:0] req_type;
        logic       outcome_ok;
        logic [1:0] forced_state;
    } in_item_t;

    typedef struct packed {
        logic               admitted;
        logic [1:0]         breaker_now;
        logic               changed;
        logic [1:0]         breaker_before;
        logic [FIELD_W-1:0] calls_seen;
        logic [FIELD_W-1:0] ok_seen;
        logic [FIELD_W-1:0] fail_seen;
        logic [FIELD_W-1:0] refused_seen;
        logic [FIELD_W-1:0] change_count;
    } out_item_t;

    // low bits of a counter, zero-extended when the counter is narrower
    function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+FIELD_W-1:0] wide;
        wide = {{FIELD_W{1'b0}}, v};
        return wide[FIELD_W-1:0];
    endfunction

endpackage

[sv/request_circuit_breaker_top.sv]
// an accepted item is held in the input register and its result in the result register
// throughput: one item per cycle unless held; each item's breaker update is one pass of logic
// between the input register and the result register, so the state register sets the pace
// an input register parts the two sides, so one item is taken while a result waits
// reset: asynchronous, active low; breaker closed, runs, age and statistics zero,
// configuration back to its defaults (5, 0, 1, 1000)
`timescale 1ns / 1ps
`include "request_circuit_breaker_top_macros.svh"

module request_circuit_breaker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rcb_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rcb_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcb_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int CW = rcb_pkg::COUNT_WIDTH;
    localparam int RW = rcb_pkg::RUN_W;
    localparam int AW = rcb_pkg::AGE_W;

    // configuration
    logic [15:0] failure_limit_reg;
    logic [31:0] min_total_calls_reg;
    logic [15:0] probe_limit_reg;
    logic [31:0] recovery_ticks_reg;

    // input stage
    logic              in_valid_reg;
    rcb_pkg::in_item_t in_item_reg;
    logic              fire;

    // breaker state
    logic [1:0]    mode_reg, mode_next;
    logic [RW-1:0] fail_run_reg, fail_run_next;
    logic [RW-1:0] ok_run_reg, ok_run_next;
    logic [AW-1:0] open_age_reg, open_age_next;
    logic          probe_reg, probe_next;
    logic [CW-1:0] calls_reg, calls_next;
    logic [CW-1:0] ok_cnt_reg, ok_cnt_next;
    logic [CW-1:0] fail_cnt_reg, fail_cnt_next;
    logic [CW-1:0] refused_reg, refused_next;
    logic [CW-1:0] changes_reg, changes_next;

    // result stage
    logic               out_valid_reg;
    rcb_pkg::out_item_t out_item_reg, out_item_next;

    logic                      admitted;
    logic                      changed;
    logic [RW-1:0]             fail_run_inc;
    logic [RW-1:0]             ok_run_inc;
    logic [rcb_pkg::CMP_W-1:0] calls_ext;
    logic [rcb_pkg::CMP_W-1:0] min_calls_ext;

    function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    function automatic logic [RW-1:0] run_inc(input logic [RW-1:0] v);
        return (&v) ? v : v + RW'(1);
    endfunction

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign fail_run_inc  = run_inc(fail_run_reg);
    assign ok_run_inc    = run_inc(ok_run_reg);
    assign calls_ext     = rcb_pkg::CMP_W'(calls_reg);
    assign min_calls_ext = rcb_pkg::CMP_W'(min_total_calls_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failure_limit_reg   <= 16'd5;
            min_total_calls_reg <= 32'd0;
            probe_limit_reg     <= 16'd1;
            recovery_ticks_reg  <= 32'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcb_pkg::CFG_FAILURE_LIMIT:   failure_limit_reg   <= cfg_data[15:0];
                rcb_pkg::CFG_MIN_TOTAL_CALLS: min_total_calls_reg <= cfg_data;
                rcb_pkg::CFG_PROBE_LIMIT:     probe_limit_reg     <= cfg_data[15:0];
                rcb_pkg::CFG_RECOVERY_TICKS:  recovery_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        fail_run_next = fail_run_reg;
        ok_run_next   = ok_run_reg;
        open_age_next = open_age_reg;
        probe_next    = probe_reg;
        calls_next    = calls_reg;
        ok_cnt_next   = ok_cnt_reg;
        fail_cnt_next = fail_cnt_reg;
        refused_next  = refused_reg;
        admitted      = 1'b0;

        case (in_item_reg.req_type)
            rcb_pkg::REQ_QUERY:
            begin
                calls_next = cnt_inc(calls_reg);
                if (mode_reg == rcb_pkg::ST_CLOSED)
                begin
                    admitted = 1'b1;
                end
                else if (mode_reg == rcb_pkg::ST_OPEN)
                begin
                    // recovery window over: this request becomes the probe
                    if (open_age_reg >= recovery_ticks_reg)
                    begin
                        mode_next  = rcb_pkg::ST_HALF;
                        probe_next = 1'b1;
                        admitted   = 1'b1;
                    end
                    else
                    begin
                        refused_next = cnt_inc(refused_reg);
                    end
                end
                else if (!probe_reg)
                begin
                    probe_next = 1'b1;
                    admitted   = 1'b1;
                end
                else
                begin
                    refused_next = cnt_inc(refused_reg);
                end
            end
            rcb_pkg::REQ_OUTCOME:
            begin
                if (in_item_reg.outcome_ok)
                    ok_cnt_next = cnt_inc(ok_cnt_reg);
                else
                    fail_cnt_next = cnt_inc(fail_cnt_reg);
                if (mode_reg == rcb_pkg::ST_CLOSED)
                begin
                    if (in_item_reg.outcome_ok)
                    begin
                        fail_run_next = '0;
                    end
                    else
                    begin
                        fail_run_next = fail_run_inc;
                        if ((fail_run_inc >= failure_limit_reg) && (calls_ext >= min_calls_ext))
                        begin
                            mode_next     = rcb_pkg::ST_OPEN;
                            open_age_next = '0;
                        end
                    end
                end
                else if (mode_reg == rcb_pkg::ST_HALF)
                begin
                    probe_next = 1'b0;
                    if (in_item_reg.outcome_ok)
                    begin
                        ok_run_next = ok_run_inc;
                        if (ok_run_inc >= probe_limit_reg)
                        begin
                            fail_run_next = '0;
                            ok_run_next   = '0;
                            mode_next     = rcb_pkg::ST_CLOSED;
                        end
                    end
                    else
                    begin
                        ok_run_next   = '0;
                        mode_next     = rcb_pkg::ST_OPEN;
                        open_age_next = '0;
                    end
                end
            end
            rcb_pkg::REQ_TICK:
            begin
                if ((mode_reg == rcb_pkg::ST_OPEN) && !(&open_age_reg))
                    open_age_next = open_age_reg + AW'(1);
            end
            rcb_pkg::REQ_FORCE:
            begin
                // the unused state code leaves everything untouched
                if (in_item_reg.forced_state <= rcb_pkg::ST_HALF)
                begin
                    if (in_item_reg.forced_state == rcb_pkg::ST_OPEN)
                        open_age_next = '0;
                    probe_next    = 1'b0;
                    fail_run_next = '0;
                    ok_run_next   = '0;
                    mode_next     = in_item_reg.forced_state;
                end
            end
            rcb_pkg::REQ_RESET:
            begin
                fail_run_next = '0;
                ok_run_next   = '0;
                probe_next    = 1'b0;
                mode_next     = rcb_pkg::ST_CLOSED;
            end
            default: ;
        endcase

        changed      = (mode_next != mode_reg);
        changes_next = changed ? cnt_inc(changes_reg) : changes_reg;

        out_item_next.admitted       = admitted;
        out_item_next.breaker_now    = mode_next;
        out_item_next.changed        = changed;
        out_item_next.breaker_before = mode_reg;
        out_item_next.calls_seen     = rcb_pkg::to_field(calls_next);
        out_item_next.ok_seen        = rcb_pkg::to_field(ok_cnt_next);
        out_item_next.fail_seen      = rcb_pkg::to_field(fail_cnt_next);
        out_item_next.refused_seen   = rcb_pkg::to_field(refused_next);
        out_item_next.change_count   = rcb_pkg::to_field(changes_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= rcb_pkg::ST_CLOSED;
            fail_run_reg  <= '0;
            ok_run_reg    <= '0;
            open_age_reg  <= '0;
            probe_reg     <= 1'b0;
            calls_reg     <= '0;
            ok_cnt_reg    <= '0;
            fail_cnt_reg  <= '0;
            refused_reg   <= '0;
            changes_reg   <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                fail_run_reg  <= fail_run_next;
                ok_run_reg    <= ok_run_next;
                open_age_reg  <= open_age_next;
                probe_reg     <= probe_next;
                calls_reg     <= calls_next;
                ok_cnt_reg    <= ok_cnt_next;
                fail_cnt_reg  <= fail_cnt_next;
                refused_reg   <= refused_next;
                changes_reg   <= changes_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_item;
        if (fire)
            out_item_reg <= out_item_next;
    end

    `RCB_ASSERT_NEXT(a_state_matches_result, fire, mode_reg == out_item_reg.breaker_now, "breaker state and result beat disagree")
    `RCB_ASSERT_NOW(a_probe_only_half_open, probe_reg, mode_reg == rcb_pkg::ST_HALF, "probe pending outside half-open")
    `RCB_ASSERT_NOW(a_admit_not_open, out_valid_reg && out_item_reg.admitted, out_item_reg.breaker_now != rcb_pkg::ST_OPEN, "request admitted while open")
    `RCB_ASSERT_NEXT(a_tick_keeps_state, fire && (in_item_reg.req_type == rcb_pkg::REQ_TICK), mode_reg == $past(mode_reg), "tick moved the breaker")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rcb_pkg::*;

    // request kinds the block ignores, and the force code that means no state
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
    localparam logic [1:0] ST_NONE         = 2'd3;

    localparam logic [63:0] CNT_TOP = (COUNT_WIDTH >= 64) ? {64{1'b1}}
                                    : ((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam int STALL_LIMIT      = 3000;
    localparam int SQUEEZE_CYCLES   = 400;
    localparam int PHASES           = 8;
    localparam int EVENTS_PER_PHASE = 178;

    typedef struct {
        bit        typed;
        out_item_t value;
    } note_t;

    typedef struct {
        bit          is_cfg;
        logic [31:0] fl;
        logic [31:0] mc;
        logic [31:0] pl;
        logic [31:0] rt;
        in_item_t    item;
        bit          typed;
        out_item_t   value;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_item_t           in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // breaker mirror and its configuration
    logic [1:0]  bk_mode = ST_CLOSED;
    logic [15:0] fail_run = '0;
    logic [15:0] ok_run = '0;
    logic [31:0] open_age = '0;
    logic        probe_out = 1'b0;
    logic [63:0] n_calls = '0;
    logic [63:0] n_ok = '0;
    logic [63:0] n_fail = '0;
    logic [63:0] n_refused = '0;
    logic [63:0] n_changes = '0;
    logic [15:0] fail_limit = 16'd5;
    logic [31:0] min_calls = 32'd0;
    logic [15:0] probe_limit = 16'd1;
    logic [31:0] recovery = 32'd1000;

    out_item_t due_results[$];
    note_t     hand_notes[$];
    row_t      plan[$];

    int errors = 0;
    int events_sent = 0;
    int results_seen = 0;
    int moves_seen = 0;
    int admits_seen = 0;
    int settings_used = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    int quiet_cycles = 0;
    int squeeze_count = 0;
    bit squeeze_req = 1'b0;

    always #5 clk = ~clk;

    request_circuit_breaker_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic bit enter_mode(logic [1:0] nx);
        if (nx == bk_mode)
            return 1'b0;
        bk_mode = nx;
        if (n_changes < CNT_TOP)
            n_changes++;
        return 1'b1;
    endfunction

    function automatic out_item_t breaker_step(in_item_t ev);
        out_item_t  res;
        logic [1:0] prior;
        logic       admit;
        logic       moved;
        prior = bk_mode;
        admit = 1'b0;
        moved = 1'b0;
        case (ev.req_type)
            REQ_QUERY:
            begin
                if (n_calls < CNT_TOP)
                    n_calls++;
                if (bk_mode == ST_CLOSED)
                    admit = 1'b1;
                else if (bk_mode == ST_OPEN)
                begin
                    if (open_age >= recovery)
                    begin
                        moved = enter_mode(ST_HALF);
                        probe_out = 1'b1;
                        admit = 1'b1;
                    end
                    else if (n_refused < CNT_TOP)
                        n_refused++;
                end
                else if (!probe_out)
                begin
                    probe_out = 1'b1;
                    admit = 1'b1;
                end
                else if (n_refused < CNT_TOP)
                    n_refused++;
            end
            REQ_OUTCOME:
            begin
                if (ev.outcome_ok)
                begin
                    if (n_ok < CNT_TOP)
                        n_ok++;
                end
                else if (n_fail < CNT_TOP)
                    n_fail++;
                if (bk_mode == ST_CLOSED)
                begin
                    if (ev.outcome_ok)
                        fail_run = '0;
                    else
                    begin
                        if (fail_run != 16'hFFFF)
                            fail_run++;
                        if (fail_run >= fail_limit && n_calls >= min_calls)
                        begin
                            moved = enter_mode(ST_OPEN);
                            open_age = '0;
                        end
                    end
                end
                else if (bk_mode == ST_HALF)
                begin
                    probe_out = 1'b0;
                    if (ev.outcome_ok)
                    begin
                        if (ok_run != 16'hFFFF)
                            ok_run++;
                        if (ok_run >= probe_limit)
                        begin
                            fail_run = '0;
                            ok_run = '0;
                            moved = enter_mode(ST_CLOSED);
                        end
                    end
                    else
                    begin
                        ok_run = '0;
                        moved = enter_mode(ST_OPEN);
                        open_age = '0;
                    end
                end
            end
            REQ_TICK:
            begin
                if (bk_mode == ST_OPEN && open_age != 32'hFFFF_FFFF)
                    open_age++;
            end
            REQ_FORCE:
            begin
                if (ev.forced_state <= ST_HALF)
                begin
                    if (ev.forced_state == ST_OPEN)
                        open_age = '0;
                    probe_out = 1'b0;
                    fail_run = '0;
                    ok_run = '0;
                    moved = enter_mode(ev.forced_state);
                end
            end
            REQ_RESET:
            begin
                fail_run = '0;
                ok_run = '0;
                probe_out = 1'b0;
                moved = enter_mode(ST_CLOSED);
            end
            default:
            begin
            end
        endcase
        res.admitted       = admit;
        res.breaker_now    = bk_mode;
        res.changed        = moved;
        res.breaker_before = prior;
        res.calls_seen     = n_calls[FIELD_W-1:0];
        res.ok_seen        = n_ok[FIELD_W-1:0];
        res.fail_seen      = n_fail[FIELD_W-1:0];
        res.refused_seen   = n_refused[FIELD_W-1:0];
        res.change_count   = n_changes[FIELD_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    function automatic in_item_t ev(logic [2:0] kind, logic ok, logic [1:0] forced);
        in_item_t it;
        it.req_type     = kind;
        it.outcome_ok   = ok;
        it.forced_state = forced;
        return it;
    endfunction

    function automatic void add_row(in_item_t it);
        row_t r;
        r = '{default: '0};
        r.item = it;
        plan.push_back(r);
    endfunction

    function automatic void add_typed(in_item_t it, int adm, logic [1:0] now, int chg,
                                      logic [1:0] prev, int c, int o, int f, int rf, int x);
        row_t r;
        r = '{default: '0};
        r.item                 = it;
        r.typed                = 1'b1;
        r.value.admitted       = 1'(adm);
        r.value.breaker_now    = now;
        r.value.changed        = 1'(chg);
        r.value.breaker_before = prev;
        r.value.calls_seen     = FIELD_W'(c);
        r.value.ok_seen        = FIELD_W'(o);
        r.value.fail_seen      = FIELD_W'(f);
        r.value.refused_seen   = FIELD_W'(rf);
        r.value.change_count   = FIELD_W'(x);
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(logic [31:0] fl, logic [31:0] mc, logic [31:0] pl,
                                    logic [31:0] rt);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.fl = fl;
        r.mc = mc;
        r.pl = pl;
        r.rt = rt;
        plan.push_back(r);
    endfunction

    // scoreboard: config beats, accepted events and returned results
    always @(posedge clk)
    begin
        out_item_t want;
        note_t     note;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FAILURE_LIMIT:   fail_limit = cfg_data[15:0];
                    CFG_MIN_TOTAL_CALLS: min_calls = cfg_data;
                    CFG_PROBE_LIMIT:     probe_limit = cfg_data[15:0];
                    CFG_RECOVERY_TICKS:  recovery = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result %0h with nothing expected", $time, out_item);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("admitted", want.admitted, out_item.admitted);
                    check_field("breaker_now", want.breaker_now, out_item.breaker_now);
                    check_field("changed", want.changed, out_item.changed);
                    check_field("breaker_before", want.breaker_before, out_item.breaker_before);
                    check_field("calls_seen", want.calls_seen, out_item.calls_seen);
                    check_field("ok_seen", want.ok_seen, out_item.ok_seen);
                    check_field("fail_seen", want.fail_seen, out_item.fail_seen);
                    check_field("refused_seen", want.refused_seen, out_item.refused_seen);
                    check_field("change_count", want.change_count, out_item.change_count);
                    moves_seen += want.changed;
                    admits_seen += want.admitted;
                end
            end
            if (in_valid && in_ready)
            begin
                want = breaker_step(in_item);
                note = hand_notes.pop_front();
                due_results.push_back(note.typed ? note.value : want);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (squeeze_req && squeeze_count < SQUEEZE_CYCLES)
        begin
            out_ready <= 1'b0;
            squeeze_count <= squeeze_count + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no beat for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, due_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(in_item_t it, bit typed, out_item_t value);
        note_t note;
        if (snd_pct != 0 && $urandom_range(99) < snd_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_pct);
        end
        note.typed = typed;
        note.value = value;
        hand_notes.push_back(note);
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        events_sent++;
    endtask

    // every event yields a result, so an empty queue means the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_config(logic [31:0] fl, logic [31:0] mc, logic [31:0] pl,
                               logic [31:0] rt);
        settle();
        cfg_write(CFG_FAILURE_LIMIT, fl);
        cfg_write(CFG_MIN_TOTAL_CALLS, mc);
        cfg_write(CFG_PROBE_LIMIT, pl);
        cfg_write(CFG_RECOVERY_TICKS, rt);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        in_item_t    it;
        out_item_t   blank;
        logic [31:0] fl;
        logic [31:0] mc;
        logic [31:0] pl;
        logic [31:0] rt;
        int          ok_pct;
        int          roll;
        int          counted;
        bit          real_event;

        blank = '0;

        // defaults after reset: limit 5, no call minimum, one probe, 1000 ticks
        add_typed(ev(REQ_QUERY, 1'b0, ST_CLOSED), 1, ST_CLOSED, 0, ST_CLOSED, 1, 0, 0, 0, 0);
        add_typed(ev(REQ_OUTCOME, 1'b0, ST_CLOSED), 0, ST_CLOSED, 0, ST_CLOSED, 1, 0, 1, 0, 0);
        add_typed(ev(REQ_TICK, 1'b1, ST_NONE), 0, ST_CLOSED, 0, ST_CLOSED, 1, 0, 1, 0, 0);
        add_typed(ev(REQ_SPARE_LAST, 1'b1, ST_NONE), 0, ST_CLOSED, 0, ST_CLOSED, 1, 0, 1, 0, 0);
        add_typed(ev(REQ_SPARE_FIRST, 1'b0, ST_CLOSED), 0, ST_CLOSED, 0, ST_CLOSED, 1, 0, 1, 0, 0);
        add_typed(ev(REQ_FORCE, 1'b0, ST_NONE), 0, ST_CLOSED, 0, ST_CLOSED, 1, 0, 1, 0, 0);
        add_typed(ev(REQ_FORCE, 1'b0, ST_OPEN), 0, ST_OPEN, 1, ST_CLOSED, 1, 0, 1, 0, 1);
        add_typed(ev(REQ_QUERY, 1'b1, ST_HALF), 0, ST_OPEN, 0, ST_OPEN, 2, 0, 1, 1, 1);
        add_typed(ev(REQ_OUTCOME, 1'b1, ST_CLOSED), 0, ST_OPEN, 0, ST_OPEN, 2, 1, 1, 1, 1);
        add_typed(ev(REQ_TICK, 1'b0, ST_CLOSED), 0, ST_OPEN, 0, ST_OPEN, 2, 1, 1, 1, 1);
        add_typed(ev(REQ_FORCE, 1'b1, ST_OPEN), 0, ST_OPEN, 0, ST_OPEN, 2, 1, 1, 1, 1);
        add_typed(ev(REQ_FORCE, 1'b0, ST_HALF), 0, ST_HALF, 1, ST_OPEN, 2, 1, 1, 1, 2);
        add_typed(ev(REQ_QUERY, 1'b0, ST_CLOSED), 1, ST_HALF, 0, ST_HALF, 3, 1, 1, 1, 2);
        add_typed(ev(REQ_QUERY, 1'b0, ST_CLOSED), 0, ST_HALF, 0, ST_HALF, 4, 1, 1, 2, 2);
        add_typed(ev(REQ_OUTCOME, 1'b1, ST_NONE), 0, ST_CLOSED, 1, ST_HALF, 4, 2, 1, 2, 3);
        add_typed(ev(REQ_RESET, 1'b1, ST_OPEN), 0, ST_CLOSED, 0, ST_CLOSED, 4, 2, 1, 2, 3);
        add_typed(ev(REQ_FORCE, 1'b0, ST_HALF), 0, ST_HALF, 1, ST_CLOSED, 4, 2, 1, 2, 4);
        add_typed(ev(REQ_RESET, 1'b0, ST_CLOSED), 0, ST_CLOSED, 1, ST_HALF, 4, 2, 1, 2, 5);
        // zero limits: first failure opens, first request probes, first success closes
        add_cfg(32'd0, 32'd0, 32'd0, 32'd0);
        add_row(ev(REQ_OUTCOME, 1'b0, ST_HALF));
        add_row(ev(REQ_QUERY, 1'b1, ST_OPEN));
        add_row(ev(REQ_OUTCOME, 1'b1, ST_HALF));
        add_row(ev(REQ_OUTCOME, 1'b0, ST_CLOSED));
        add_row(ev(REQ_TICK, 1'b1, ST_OPEN));
        add_row(ev(REQ_QUERY, 1'b0, ST_NONE));
        // failed probe goes straight back to open
        add_row(ev(REQ_OUTCOME, 1'b0, ST_OPEN));
        add_cfg(32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
        add_row(ev(REQ_FORCE, 1'b1, ST_CLOSED));
        add_row(ev(REQ_OUTCOME, 1'b0, ST_HALF));
        add_row(ev(REQ_TICK, 1'b0, ST_OPEN));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                load_config(plan[i].fl, plan[i].mc, plan[i].pl, plan[i].rt);
            else
                send_item(plan[i].item, plan[i].typed, plan[i].value);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    fl = 32'd0;
                    mc = 32'd0;
                    pl = 32'd0;
                    rt = 32'd0;
                end
                6:
                begin
                    fl = 32'h0000_FFFF;
                    mc = 32'hFFFF_FFFF;
                    pl = 32'h0000_FFFF;
                    rt = 32'hFFFF_FFFF;
                end
                default:
                begin
                    fl = $urandom_range(1, 4);
                    // the call minimum sits at or just above the running total so it bites
                    mc = n_calls[31:0] + $urandom_range(0, 40);
                    pl = $urandom_range(1, 3);
                    rt = $urandom_range(0, 6);
                end
            endcase
            load_config(fl, mc, pl, rt);
            case (p % 4)
                0:
                begin
                    snd_pct = 0;
                    rcv_pct <= 0;
                end
                1:
                begin
                    snd_pct = 60;
                    rcv_pct <= 0;
                end
                2:
                begin
                    snd_pct = 0;
                    rcv_pct <= 60;
                end
                default:
                begin
                    snd_pct = 13;
                    rcv_pct <= 13;
                end
            endcase
            if (p == 4)
                squeeze_req <= 1'b1;
            ok_pct = $urandom_range(35, 75);
            counted = 0;
            while (counted < EVENTS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                it.outcome_ok = 1'($urandom_range(1));
                it.forced_state = 2'($urandom_range(3));
                real_event = 1'b1;
                if (roll < 30)
                    it.req_type = REQ_QUERY;
                else if (roll < 62)
                begin
                    it.req_type = REQ_OUTCOME;
                    it.outcome_ok = ($urandom_range(99) < ok_pct);
                end
                else if (roll < 84)
                    it.req_type = REQ_TICK;
                else if (roll < 91)
                begin
                    it.req_type = REQ_FORCE;
                    real_event = (it.forced_state != ST_NONE);
                end
                else if (roll < 95)
                    it.req_type = REQ_RESET;
                else
                begin
                    it.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
                    real_event = 1'b0;
                end
                send_item(it, 1'b0, blank);
                if (real_event)
                    counted++;
            end
        end

        snd_pct = 0;
        rcv_pct <= 0;
        settle();
        repeat (8) @(posedge clk);

        $display("run covered %0d events under %0d register settings, %0d results checked",
                 events_sent, settings_used, results_seen);
        $display("breaker moved %0d times, admitted %0d requests, refused %0d",
                 moves_seen, admits_seen, n_refused);
        if (errors == 0 && due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
